### rtl/tsm_pkg.sv
package tsm_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned BIDX_W  = 6;
  localparam int unsigned RANKS_W = 7;
  localparam int unsigned GS_W    = 3;

  // Granule shift limits and reset value
  localparam logic [GS_W-1:0] GS_MAX   = 3'd4;
  localparam logic [GS_W-1:0] GS_RESET = 3'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_LOOKUP   = 2'd1,
    CMD_LOAD_BND = 2'd2,
    CMD_COMPRESS = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_C_RD,
    ST_C_CHK,
    ST_C_SCAN
  } state_e;

endpackage

### rtl/timestamp_shadow_memory.sv
// Timestamp shadow memory. One 32-bit stamp per address granule of a 2^ADDR_BITS byte
// window, granule size 2^granule_shift bytes (shift values above 4 act as 4). A command
// is taken when start is high and busy is low; each command gives exactly one result
// beat on valid_o/value_o, one cycle wide, which the receiver cannot stall. After reset
// the block sweeps the store to zero, one entry per cycle, with busy high; configuration
// writes are taken during the sweep. Load boundary answers in the cycle after start and
// leaves busy low. Insert and lookup do one store read, then the write-back, with busy
// high during the write-back. Compress walks the store one entry at a time: each entry
// is read and checked, and a nonzero entry then has its boundaries examined one at a
// time (up to min(rank_count, MAX_RANKS)), since a single comparator scans the boundary
// table from the top down. Its result beat follows the last entry.
module timestamp_shadow_memory #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned MAX_RANKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsm_pkg::CMD_W-1:0]     command_i,
  input  logic [ADDR_BITS-1:0]          address_i,
  input  logic [tsm_pkg::TS_W-1:0]      timestamp_i,
  input  logic [tsm_pkg::BIDX_W-1:0]    boundary_index_i,
  input  logic [tsm_pkg::RANKS_W-1:0]   rank_count_i,
  input  logic                          cfg_we_i,
  input  logic [tsm_pkg::GS_W-1:0]      cfg_wdata_i,
  output logic                          valid_o,
  output logic [tsm_pkg::TS_W-1:0]      value_o
);

  import tsm_pkg::*;

  localparam longint unsigned STORE_DEPTH = 64'd1 << ADDR_BITS;
  localparam int unsigned     RIDX_W      = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int unsigned     KW          = $clog2(MAX_RANKS + 1);

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [GS_W-1:0]      gs_q;
  logic [ADDR_BITS-1:0] ent_q, ent_d;
  logic [TS_W-1:0]      ts_q, ts_d;
  logic [KW-1:0]        n_q, n_d;
  logic [KW-1:0]        k_q, k_d;
  logic [TS_W-1:0]      stamp_q, stamp_d;
  logic                 valid_q, valid_d;
  logic [TS_W-1:0]      value_q, value_d;

  // Store and table ports
  logic                 st_we;
  logic [ADDR_BITS-1:0] st_waddr, st_raddr;
  logic [TS_W-1:0]      st_wdata, st_rdata;
  logic                 bt_we;
  logic [RIDX_W-1:0]    bt_waddr, bt_raddr;
  logic [TS_W-1:0]      bt_rdata;

  logic                 accept;
  logic [GS_W-1:0]      shift;
  logic [ADDR_BITS-1:0] in_entry;
  logic                 ent_last;

  tsm_ram #(
    .WIDTH (TS_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  tsm_ram #(
    .WIDTH (TS_W),
    .DEPTH (longint'(MAX_RANKS))
  ) u_bound (
    .clk_i   (clk_i),
    .we_i    (bt_we),
    .waddr_i (bt_waddr),
    .wdata_i (timestamp_i),
    .raddr_i (bt_raddr),
    .rdata_o (bt_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Granule mapping
  assign shift    = (gs_q > GS_MAX) ? GS_MAX : gs_q;
  assign in_entry = address_i >> shift;
  assign ent_last = (ent_q == {ADDR_BITS{1'b1}});

  // Boundary load goes straight into the table
  assign bt_we    = accept && (cmd_e'(command_i) == CMD_LOAD_BND)
                    && (32'(boundary_index_i) < 32'(MAX_RANKS));
  assign bt_waddr = RIDX_W'(boundary_index_i);

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GS_RESET;
    end else if (cfg_we_i) begin
      gs_q <= cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cmd_q   <= CMD_INSERT;
      ent_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      ent_q   <= ent_d;
      n_q     <= n_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ts_q    <= ts_d;
    stamp_q <= stamp_d;
    value_q <= value_d;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    ent_d    = ent_q;
    ts_d     = ts_q;
    n_d      = n_q;
    k_d      = k_q;
    stamp_d  = stamp_q;
    valid_d  = 1'b0;
    value_d  = value_q;
    st_we    = 1'b0;
    st_waddr = ent_q;
    st_wdata = '0;
    st_raddr = ent_q;
    bt_raddr = RIDX_W'(n_q - KW'(1));

    case (state_q)
      ST_CLEAR: begin
        st_we = 1'b1;
        if (ent_last) begin
          ent_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ent_d = ent_q + ADDR_BITS'(1);
        end
      end

      ST_IDLE: begin
        st_raddr = in_entry;
        if (accept) begin
          cmd_d = cmd_e'(command_i);
          ts_d  = timestamp_i;
          case (cmd_e'(command_i))
            CMD_INSERT, CMD_LOOKUP: begin
              ent_d   = in_entry;
              state_d = ST_RMW;
            end
            CMD_LOAD_BND: begin
              valid_d = 1'b1;
              value_d = '0;
            end
            CMD_COMPRESS: begin
              ent_d   = '0;
              n_d     = (32'(rank_count_i) > 32'(MAX_RANKS)) ? KW'(MAX_RANKS)
                                                             : KW'(rank_count_i);
              state_d = ST_C_RD;
            end
            default: ;
          endcase
        end
      end

      // Old stamp is on the read port; keep the larger one
      ST_RMW: begin
        st_we    = (cmd_q == CMD_INSERT) && (st_rdata < ts_q);
        st_wdata = ts_q;
        valid_d  = 1'b1;
        value_d  = st_rdata;
        state_d  = ST_IDLE;
      end

      ST_C_RD: begin
        state_d = ST_C_CHK;
      end

      // Entry read back: skip zero, clear when no ranks, else start the scan
      ST_C_CHK: begin
        stamp_d = st_rdata;
        k_d     = n_q;
        if ((st_rdata != '0) && (n_q != '0)) begin
          state_d = ST_C_SCAN;
        end else begin
          st_we = (st_rdata != '0);
          if (ent_last) begin
            ent_d   = '0;
            valid_d = 1'b1;
            value_d = '0;
            state_d = ST_IDLE;
          end else begin
            ent_d   = ent_q + ADDR_BITS'(1);
            state_d = ST_C_RD;
          end
        end
      end

      // Boundary k-1 on the read port; step down until one fits
      ST_C_SCAN: begin
        bt_raddr = RIDX_W'(k_q - KW'(2));
        if ((bt_rdata <= stamp_q) || (k_q == KW'(1))) begin
          st_we    = 1'b1;
          st_wdata = (bt_rdata <= stamp_q) ? TS_W'(k_q) : '0;
          if (ent_last) begin
            ent_d   = '0;
            valid_d = 1'b1;
            value_d = '0;
            state_d = ST_IDLE;
          end else begin
            ent_d   = ent_q + ADDR_BITS'(1);
            state_d = ST_C_RD;
          end
        end else begin
          k_d = k_q - KW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

  // Insert and lookup hold busy for the write-back cycle
  a_rmw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ((cmd_e'(command_i) == CMD_INSERT) || (cmd_e'(command_i) == CMD_LOOKUP))
    |=> (state_q == ST_RMW) && busy)
    else $error("insert/lookup did not enter write-back");

  // Write-back always yields a result beat next cycle
  a_rmw_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |=> valid_o)
    else $error("missing result beat after write-back");

  // Boundary scan never runs with an empty rank index
  a_scan_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_C_SCAN) |-> (k_q != '0) && (k_q <= n_q))
    else $error("boundary scan index out of range");

  // No result beat while the store is being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !valid_o)
    else $error("result beat during clearing sweep");

endmodule

### rtl/tsm_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module tsm_ram #(
  parameter int unsigned          WIDTH = 32,
  parameter longint unsigned      DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
